### rtl/ebceu_pkg.sv
// Shared types and constants for the 8-bit CPU execute unit.
package ebceu_pkg;

    // Operation codes as they arrive on the action port
    typedef enum logic [5:0] {
        ACT_LDA = 6'd0,  ACT_LDX = 6'd1,  ACT_LDY = 6'd2,  ACT_STA = 6'd3,
        ACT_STX = 6'd4,  ACT_STY = 6'd5,  ACT_TAX = 6'd6,  ACT_TAY = 6'd7,
        ACT_TXA = 6'd8,  ACT_TYA = 6'd9,  ACT_TSX = 6'd10, ACT_TXS = 6'd11,
        ACT_PHA = 6'd12, ACT_PHP = 6'd13, ACT_PLA = 6'd14, ACT_PLP = 6'd15,
        ACT_AND = 6'd16, ACT_EOR = 6'd17, ACT_ORA = 6'd18, ACT_BIT = 6'd19,
        ACT_CLC = 6'd20, ACT_CLD = 6'd21, ACT_CLI = 6'd22, ACT_CLV = 6'd23,
        ACT_SEC = 6'd24, ACT_SED = 6'd25, ACT_SEI = 6'd26, ACT_ADC = 6'd27,
        ACT_SBC = 6'd28, ACT_CMP = 6'd29, ACT_CPX = 6'd30, ACT_CPY = 6'd31,
        ACT_INC = 6'd32, ACT_INX = 6'd33, ACT_INY = 6'd34, ACT_DEC = 6'd35,
        ACT_DEX = 6'd36, ACT_DEY = 6'd37, ACT_ASL = 6'd38, ACT_LSR = 6'd39,
        ACT_ROL = 6'd40, ACT_ROR = 6'd41, ACT_NOP = 6'd42
    } action_t;

    // Operation classes seen by the execute side
    typedef enum logic [3:0] {
        CLS_NOP,
        CLS_MOVE,
        CLS_PUSH,
        CLS_PULL,
        CLS_LOGIC,
        CLS_BIT,
        CLS_FLAG,
        CLS_ADD,
        CLS_CMP,
        CLS_INCDEC,
        CLS_SHIFT
    } op_class_t;

    // Register or memory selector for source and destination
    typedef enum logic [2:0] {
        SEL_A,
        SEL_X,
        SEL_Y,
        SEL_S,
        SEL_M
    } reg_sel_t;

    // Sub-operation codes, meaning depends on class
    localparam logic [2:0] LOG_AND    = 3'd0;
    localparam logic [2:0] LOG_EOR    = 3'd1;
    localparam logic [2:0] LOG_ORA    = 3'd2;
    localparam logic [2:0] SH_ASL     = 3'd0;
    localparam logic [2:0] SH_LSR     = 3'd1;
    localparam logic [2:0] SH_ROL     = 3'd2;
    localparam logic [2:0] SH_ROR     = 3'd3;
    localparam logic [2:0] ID_INC     = 3'd0;
    localparam logic [2:0] ID_DEC     = 3'd1;
    localparam logic [2:0] STK_ACC    = 3'd0;
    localparam logic [2:0] STK_STATUS = 3'd1;
    localparam logic [2:0] ADD_ADC    = 3'd0;
    localparam logic [2:0] ADD_SBC    = 3'd1;

    // Status bit positions (flag ops carry one of these as sub code)
    localparam logic [2:0] FB_C = 3'd0;
    localparam logic [2:0] FB_Z = 3'd1;
    localparam logic [2:0] FB_I = 3'd2;
    localparam logic [2:0] FB_D = 3'd3;
    localparam logic [2:0] FB_V = 3'd6;
    localparam logic [2:0] FB_N = 3'd7;

    localparam logic [7:0] FL_B        = 8'h10;
    localparam logic [7:0] FL_U        = 8'h20;
    localparam logic [7:0] STATUS_INIT = 8'h20;
    localparam logic [8:0] STACK_PAGE  = 9'h100;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Decoded operation
    typedef struct packed {
        op_class_t  cls;
        reg_sel_t   src;
        reg_sel_t   dst;
        logic [2:0] sub;
        logic       flag_val;
        logic [7:0] operand;
    } uop_t;

    // Queue handshake toward the back end
    typedef struct packed {
        logic valid;
        uop_t uop;
    } q_head_t;

endpackage

### rtl/ebceu_front.sv
// Front end: accepts operations and decodes them into class and selectors.
module ebceu_front (
    input  logic                push,
    output logic                full,
    input  logic [5:0]          action,
    input  logic [7:0]          operand,
    input  logic                acc_mode,
    input  logic                q_full,
    output logic                q_wr,
    output ebceu_pkg::uop_t     q_data
);
    import ebceu_pkg::*;

    uop_t     uop;
    reg_sel_t shift_sel;

    // Accept when the queue has room
    assign full   = q_full;
    assign q_wr   = push & ~q_full;
    assign q_data = uop;

    assign shift_sel = acc_mode ? SEL_A : SEL_M;

    // Operation decoder
    always_comb
    begin
        uop.cls      = CLS_NOP;
        uop.src      = SEL_M;
        uop.dst      = SEL_A;
        uop.sub      = 3'd0;
        uop.flag_val = 1'b0;
        uop.operand  = operand;
        unique case (action_t'(action))
            ACT_LDA: begin uop.cls = CLS_MOVE; uop.src = SEL_M; uop.dst = SEL_A; end
            ACT_LDX: begin uop.cls = CLS_MOVE; uop.src = SEL_M; uop.dst = SEL_X; end
            ACT_LDY: begin uop.cls = CLS_MOVE; uop.src = SEL_M; uop.dst = SEL_Y; end
            ACT_STA: begin uop.cls = CLS_MOVE; uop.src = SEL_A; uop.dst = SEL_M; end
            ACT_STX: begin uop.cls = CLS_MOVE; uop.src = SEL_X; uop.dst = SEL_M; end
            ACT_STY: begin uop.cls = CLS_MOVE; uop.src = SEL_Y; uop.dst = SEL_M; end
            ACT_TAX: begin uop.cls = CLS_MOVE; uop.src = SEL_A; uop.dst = SEL_X; end
            ACT_TAY: begin uop.cls = CLS_MOVE; uop.src = SEL_A; uop.dst = SEL_Y; end
            ACT_TXA: begin uop.cls = CLS_MOVE; uop.src = SEL_X; uop.dst = SEL_A; end
            ACT_TYA: begin uop.cls = CLS_MOVE; uop.src = SEL_Y; uop.dst = SEL_A; end
            ACT_TSX: begin uop.cls = CLS_MOVE; uop.src = SEL_S; uop.dst = SEL_X; end
            ACT_TXS: begin uop.cls = CLS_MOVE; uop.src = SEL_X; uop.dst = SEL_S; end
            ACT_PHA: begin uop.cls = CLS_PUSH; uop.sub = STK_ACC; end
            ACT_PHP: begin uop.cls = CLS_PUSH; uop.sub = STK_STATUS; end
            ACT_PLA: begin uop.cls = CLS_PULL; uop.sub = STK_ACC; end
            ACT_PLP: begin uop.cls = CLS_PULL; uop.sub = STK_STATUS; end
            ACT_AND: begin uop.cls = CLS_LOGIC; uop.sub = LOG_AND; end
            ACT_EOR: begin uop.cls = CLS_LOGIC; uop.sub = LOG_EOR; end
            ACT_ORA: begin uop.cls = CLS_LOGIC; uop.sub = LOG_ORA; end
            ACT_BIT: uop.cls = CLS_BIT;
            ACT_CLC: begin uop.cls = CLS_FLAG; uop.sub = FB_C; uop.flag_val = 1'b0; end
            ACT_CLD: begin uop.cls = CLS_FLAG; uop.sub = FB_D; uop.flag_val = 1'b0; end
            ACT_CLI: begin uop.cls = CLS_FLAG; uop.sub = FB_I; uop.flag_val = 1'b0; end
            ACT_CLV: begin uop.cls = CLS_FLAG; uop.sub = FB_V; uop.flag_val = 1'b0; end
            ACT_SEC: begin uop.cls = CLS_FLAG; uop.sub = FB_C; uop.flag_val = 1'b1; end
            ACT_SED: begin uop.cls = CLS_FLAG; uop.sub = FB_D; uop.flag_val = 1'b1; end
            ACT_SEI: begin uop.cls = CLS_FLAG; uop.sub = FB_I; uop.flag_val = 1'b1; end
            ACT_ADC: begin uop.cls = CLS_ADD; uop.sub = ADD_ADC; end
            ACT_SBC: begin uop.cls = CLS_ADD; uop.sub = ADD_SBC; end
            ACT_CMP: begin uop.cls = CLS_CMP; uop.src = SEL_A; end
            ACT_CPX: begin uop.cls = CLS_CMP; uop.src = SEL_X; end
            ACT_CPY: begin uop.cls = CLS_CMP; uop.src = SEL_Y; end
            ACT_INC:
            begin
                uop.cls = CLS_INCDEC; uop.src = SEL_M; uop.dst = SEL_M; uop.sub = ID_INC;
            end
            ACT_INX:
            begin
                uop.cls = CLS_INCDEC; uop.src = SEL_X; uop.dst = SEL_X; uop.sub = ID_INC;
            end
            ACT_INY:
            begin
                uop.cls = CLS_INCDEC; uop.src = SEL_Y; uop.dst = SEL_Y; uop.sub = ID_INC;
            end
            ACT_DEC:
            begin
                uop.cls = CLS_INCDEC; uop.src = SEL_M; uop.dst = SEL_M; uop.sub = ID_DEC;
            end
            ACT_DEX:
            begin
                uop.cls = CLS_INCDEC; uop.src = SEL_X; uop.dst = SEL_X; uop.sub = ID_DEC;
            end
            ACT_DEY:
            begin
                uop.cls = CLS_INCDEC; uop.src = SEL_Y; uop.dst = SEL_Y; uop.sub = ID_DEC;
            end
            ACT_ASL:
            begin
                uop.cls = CLS_SHIFT; uop.src = shift_sel; uop.dst = shift_sel; uop.sub = SH_ASL;
            end
            ACT_LSR:
            begin
                uop.cls = CLS_SHIFT; uop.src = shift_sel; uop.dst = shift_sel; uop.sub = SH_LSR;
            end
            ACT_ROL:
            begin
                uop.cls = CLS_SHIFT; uop.src = shift_sel; uop.dst = shift_sel; uop.sub = SH_ROL;
            end
            ACT_ROR:
            begin
                uop.cls = CLS_SHIFT; uop.src = shift_sel; uop.dst = shift_sel; uop.sub = SH_ROR;
            end
            default: uop.cls = CLS_NOP;
        endcase
    end

endmodule

### rtl/ebceu_queue.sv
// Short queue of decoded operations between front and back end.
module ebceu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ebceu_pkg::uop_t     wr_data,
    output logic                q_full,
    input  logic                rd_en,
    output ebceu_pkg::q_head_t  head
);
    import ebceu_pkg::*;

    uop_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_wr, do_rd;

    assign q_full     = (count_reg == (QAW+1)'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.uop   = mem[rd_ptr_reg];

    assign do_wr = wr_en & ~q_full;
    assign do_rd = rd_en & head.valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/ebceu_back.sv
// Back end: register file, ALU and flag logic, plus the result register.
module ebceu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ebceu_pkg::q_head_t  head,
    output logic                rd_en,
    output logic                empty,
    input  logic                pop,
    output logic                write_enable,
    output logic [7:0]          write_data,
    output logic                stack_used,
    output logic [8:0]          stack_addr,
    output logic [7:0]          acc_out,
    output logic [7:0]          x_out,
    output logic [7:0]          y_out,
    output logic [7:0]          sp_out,
    output logic [7:0]          status_out
);
    import ebceu_pkg::*;

    // Architectural registers
    logic [7:0] a_reg, a_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] s_reg, s_next;
    logic [7:0] p_reg, p_next;

    // Result register
    logic       out_valid_reg;
    logic       we_reg, su_reg;
    logic [7:0] wd_reg;
    logic [8:0] sa_reg;

    logic       fire;
    logic       we, su, dst_wr, nz_en;
    logic [7:0] wd, src_val, res, m, m_add, s_inc;
    logic [8:0] sa, sum, diff;
    uop_t       u;

    assign u     = head.uop;
    assign m     = u.operand;
    assign fire  = head.valid & (~out_valid_reg | pop);
    assign rd_en = fire;
    assign s_inc = s_reg + 8'd1;
    assign m_add = (u.sub == ADD_SBC) ? ~m : m;
    assign sum   = {1'b0, a_reg} + {1'b0, m_add} + {8'd0, p_reg[FB_C]};
    assign diff  = {1'b0, src_val} - {1'b0, m};

    // Source select
    always_comb
    begin
        case (u.src)
            SEL_A:   src_val = a_reg;
            SEL_X:   src_val = x_reg;
            SEL_Y:   src_val = y_reg;
            SEL_S:   src_val = s_reg;
            default: src_val = m;
        endcase
    end

    // Execute one operation
    always_comb
    begin
        a_next = a_reg;
        x_next = x_reg;
        y_next = y_reg;
        s_next = s_reg;
        p_next = p_reg;
        we     = 1'b0;
        wd     = 8'd0;
        su     = 1'b0;
        sa     = STACK_PAGE;
        res    = src_val;
        dst_wr = 1'b0;
        nz_en  = 1'b0;
        unique case (u.cls)
            CLS_MOVE:
            begin
                dst_wr = 1'b1;
                nz_en  = (u.dst != SEL_S) && (u.dst != SEL_M);
            end
            CLS_PUSH:
            begin
                we     = 1'b1;
                su     = 1'b1;
                sa     = {1'b1, s_reg};
                wd     = (u.sub == STK_STATUS) ? (p_reg | FL_B | FL_U) : a_reg;
                s_next = s_reg - 8'd1;
            end
            CLS_PULL:
            begin
                su     = 1'b1;
                sa     = {1'b1, s_inc};
                s_next = s_inc;
                if (u.sub == STK_STATUS)
                begin
                    p_next = (m & ~FL_B) | FL_U;
                end
                else
                begin
                    res    = m;
                    dst_wr = 1'b1;
                    nz_en  = 1'b1;
                end
            end
            CLS_LOGIC:
            begin
                case (u.sub)
                    LOG_AND: res = a_reg & m;
                    LOG_EOR: res = a_reg ^ m;
                    default: res = a_reg | m;
                endcase
                dst_wr = 1'b1;
                nz_en  = 1'b1;
            end
            CLS_BIT:
            begin
                p_next[FB_Z] = ((a_reg & m) == 8'd0);
                p_next[FB_N] = m[7];
                p_next[FB_V] = m[6];
            end
            CLS_FLAG:
            begin
                p_next[u.sub] = u.flag_val;
            end
            CLS_ADD:
            begin
                res          = sum[7:0];
                p_next[FB_C] = sum[8];
                p_next[FB_V] = (~(a_reg[7] ^ m_add[7])) & (a_reg[7] ^ sum[7]);
                dst_wr       = 1'b1;
                nz_en        = 1'b1;
            end
            CLS_CMP:
            begin
                p_next[FB_C] = ~diff[8];
                p_next[FB_Z] = (src_val == m);
                p_next[FB_N] = diff[7];
            end
            CLS_INCDEC:
            begin
                res    = (u.sub == ID_DEC) ? src_val - 8'd1 : src_val + 8'd1;
                dst_wr = 1'b1;
                nz_en  = 1'b1;
            end
            CLS_SHIFT:
            begin
                case (u.sub)
                    SH_ASL:
                    begin
                        res          = {src_val[6:0], 1'b0};
                        p_next[FB_C] = src_val[7];
                    end
                    SH_ROL:
                    begin
                        res          = {src_val[6:0], p_reg[FB_C]};
                        p_next[FB_C] = src_val[7];
                    end
                    SH_LSR:
                    begin
                        res          = {1'b0, src_val[7:1]};
                        p_next[FB_C] = src_val[0];
                    end
                    default:
                    begin
                        res          = {p_reg[FB_C], src_val[7:1]};
                        p_next[FB_C] = src_val[0];
                    end
                endcase
                dst_wr = 1'b1;
                nz_en  = 1'b1;
            end
            default:
            begin
                dst_wr = 1'b0;
            end
        endcase

        // Destination write-back
        if (dst_wr)
        begin
            case (u.dst)
                SEL_A:   a_next = res;
                SEL_X:   x_next = res;
                SEL_Y:   y_next = res;
                SEL_S:   s_next = res;
                default:
                begin
                    we = 1'b1;
                    wd = res;
                end
            endcase
        end

        // N and Z from the result
        if (nz_en)
        begin
            p_next[FB_Z] = (res == 8'd0);
            p_next[FB_N] = res[7];
        end
    end

    // Register file update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= 8'd0;
            x_reg <= 8'd0;
            y_reg <= 8'd0;
            s_reg <= 8'd0;
            p_reg <= STATUS_INIT;
        end
        else if (fire)
        begin
            a_reg <= a_next;
            x_reg <= x_next;
            y_reg <= y_next;
            s_reg <= s_next;
            p_reg <= p_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            we_reg <= we;
            wd_reg <= wd;
            su_reg <= su;
            sa_reg <= sa;
        end
    end

    assign empty         = ~out_valid_reg;
    assign write_enable  = we_reg;
    assign write_data    = wd_reg;
    assign stack_used    = su_reg;
    assign stack_addr    = sa_reg;
    assign acc_out       = a_reg;
    assign x_out         = x_reg;
    assign y_out         = y_reg;
    assign sp_out        = s_reg;
    assign status_out    = p_reg;

endmodule

### rtl/eight_bit_cpu_execute_unit_top.sv
// Top level of the 8-bit CPU execute unit.
//
// Execute stage of an 8-bit processor holding A, X, Y, S and P.
// Input channel: push/full. An operation (action, operand, acc_mode)
// transfers on a rising edge with push high and full low.
// Result channel: empty/pop. While empty is low the oldest result is on the
// result ports; it transfers on a rising edge with pop high.
// Each operation gives exactly one result: memory/stack write, stack
// address and all registers after the operation.
// An operation is decoded into the two-entry queue at its transfer edge
// and is then executed into the result register, which shows its result.
// The back end takes one operation per cycle while the result register
// is empty or being popped; its ALU and register update are combinational.
// If the receiver stalls, the result register holds and the queue fills;
// full rises once it holds two operations and drops once results drain.
// Reset (rst_n low) empties the queue and result register and sets A, X, Y
// and S to zero and P to 0x20.
module eight_bit_cpu_execute_unit_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [5:0] action,
    input  logic [7:0] operand,
    input  logic       acc_mode,
    output logic       empty,
    input  logic       pop,
    output logic       write_enable,
    output logic [7:0] write_data,
    output logic       stack_used,
    output logic [8:0] stack_addr,
    output logic [7:0] acc_out,
    output logic [7:0] x_out,
    output logic [7:0] y_out,
    output logic [7:0] sp_out,
    output logic [7:0] status_out
);
    import ebceu_pkg::*;

    logic    q_full, q_wr, rd_en;
    uop_t    q_data;
    q_head_t head;

    ebceu_front u_front (
        .push             (push),
        .full             (full),
        .action           (action),
        .operand          (operand),
        .acc_mode         (acc_mode),
        .q_full           (q_full),
        .q_wr             (q_wr),
        .q_data           (q_data)
    );

    ebceu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_data),
        .q_full  (q_full),
        .rd_en   (rd_en),
        .head    (head)
    );

    ebceu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .rd_en         (rd_en),
        .empty         (empty),
        .pop           (pop),
        .write_enable  (write_enable),
        .write_data    (write_data),
        .stack_used    (stack_used),
        .stack_addr    (stack_addr),
        .acc_out       (acc_out),
        .x_out         (x_out),
        .y_out         (y_out),
        .sp_out        (sp_out),
        .status_out    (status_out)
    );

endmodule
